// ===== hw/rtl/srrw_pkg.sv =====
// Shared types and constants for the selective-repeat receive window.
`timescale 1ns / 1ps

package srrw_pkg;

  localparam int unsigned WINDOW_DEF   = 32;
  localparam int unsigned SEQ_BITS_DEF = 16;

  localparam int unsigned SEQ_W = 16;
  localparam int unsigned LEN_W = 15;
  localparam int unsigned PAY_W = 32;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_DLV = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_no;
    logic [LEN_W-1:0] block_len;
    logic [PAY_W-1:0] payload;
  } frame_t;

  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] out_seq;
    logic [LEN_W-1:0] out_len;
    logic [PAY_W-1:0] out_payload;
    logic             last;
    logic             done_res;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ACK,
    ST_DLV
  } state_t;

endpackage

// ===== hw/rtl/srrw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module srrw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/selective_repeat_receive_window_unit.sv =====
// Selective-repeat receive window: acknowledge, store and release frames in order.
//
// Usage:
//   in_valid/in_ready/in_data carry one data frame (sequence, length, payload).
//   out_valid/out_ready/out_data carry results: first an acknowledgement of the
//   frame, then zero or more in-order deliveries; last marks the final result
//   of a frame. Frames at or beyond the window's upper edge give no result.
//   cfg_valid/cfg_ready/cfg_data write last_sequence; write it while idle.
// Timing:
//   One frame at a time. A dropped frame passes through EVAL only, an
//   acknowledged one through EVAL and ACK plus one DLV step per delivered
//   block. The delivery walk does one slot RAM read per block, prefetched
//   while the previous block leaves. The acknowledgement is loaded in ACK.
// Reset:
//   rst_n clears next expected, the received marks, the finished flag and
//   last_sequence; the slot RAM is not cleared, its entries are read only
//   after being written.
// Stall:
//   A result waits in the output register while out_ready is low; the walk
//   holds, and no new frame is taken until the last result is loaded.
`timescale 1ns / 1ps

module selective_repeat_receive_window_unit #(
  parameter int unsigned WINDOW   = srrw_pkg::WINDOW_DEF,
  parameter int unsigned SEQ_BITS = srrw_pkg::SEQ_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  srrw_pkg::frame_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output srrw_pkg::result_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [srrw_pkg::SEQ_W-1:0]   cfg_data
);

  localparam int unsigned SeqW  = srrw_pkg::SEQ_W;
  localparam int unsigned LenW  = srrw_pkg::LEN_W;
  localparam int unsigned PayW  = srrw_pkg::PAY_W;
  localparam int unsigned SlotW = $clog2(WINDOW);
  localparam int unsigned EntW  = LenW + PayW;
  localparam logic [SlotW-1:0]  SlotLast = SlotW'(WINDOW - 1);
  localparam logic [SlotW:0]    WinSlot  = (SlotW + 1)'(WINDOW);
  localparam logic [SEQ_BITS:0] WinSeq   = (SEQ_BITS + 1)'(WINDOW);

  srrw_pkg::state_t      state_r, state_nxt;
  logic [SEQ_BITS-1:0]   seq_r, seq_nxt;
  logic [LenW-1:0]       len_r, len_nxt;
  logic [PayW-1:0]       pay_r, pay_nxt;
  logic [SEQ_BITS-1:0]   ne_r, ne_nxt;
  logic [SlotW-1:0]      ne_slot_r, ne_slot_nxt;
  logic [WINDOW-1:0]     marks_r, marks_nxt;
  logic                  fin_r, fin_nxt;
  logic [SeqW-1:0]       last_seq_r, last_seq_nxt;
  logic                  walk_r, walk_nxt;
  logic                  out_valid_r, out_valid_nxt;
  srrw_pkg::result_t     out_data_r, out_data_nxt;

  logic [SEQ_BITS:0]     upper;
  logic                  in_win;
  logic                  store_ok;
  logic [SEQ_BITS-1:0]   diff;
  logic [SlotW:0]        slot_sum;
  logic [SlotW-1:0]      in_slot;
  logic                  is_new;
  logic                  walk_has;
  logic [SEQ_BITS-1:0]   ne_inc;
  logic [SlotW-1:0]      ne_slot_inc;
  logic                  hit_last;
  logic                  more;
  logic                  can_load;

  logic                  take;
  logic                  store;
  logic                  advance;
  logic                  out_load;
  logic                  ram_re;
  logic [SlotW-1:0]      ram_raddr;
  logic [EntW-1:0]       ram_rdata;

  // Window arithmetic on the held frame.
  always_comb begin
    upper    = {1'b0, ne_r} + WinSeq;
    in_win   = {1'b0, seq_r} < upper;
    store_ok = !fin_r && (seq_r >= ne_r);
    diff     = seq_r - ne_r;
    // Offset is below WINDOW whenever the frame is stored.
    slot_sum = {1'b0, ne_slot_r} + {1'b0, diff[SlotW-1:0]};
    if (slot_sum >= WinSlot) begin
      in_slot = SlotW'(slot_sum - WinSlot);
    end else begin
      in_slot = slot_sum[SlotW-1:0];
    end
    is_new   = store_ok && !marks_r[in_slot];
    walk_has = store_ok && (marks_r[ne_slot_r] || (is_new && (in_slot == ne_slot_r)));
  end

  // Walk position one block ahead; slot restarts at zero after the last slot or when the sequence wraps.
  always_comb begin
    ne_inc = ne_r + 1'b1;
    if (ne_r == '1) begin
      ne_slot_inc = '0;
    end else if (ne_slot_r == SlotLast) begin
      ne_slot_inc = '0;
    end else begin
      ne_slot_inc = ne_slot_r + 1'b1;
    end
    hit_last = (ne_r == SEQ_BITS'(last_seq_r));
    more     = !hit_last && marks_r[ne_slot_inc];
    can_load = !out_valid_r || out_ready;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srrw_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = srrw_pkg::ST_EVAL;
        end
      end
      srrw_pkg::ST_EVAL: begin
        state_nxt = in_win ? srrw_pkg::ST_ACK : srrw_pkg::ST_IDLE;
      end
      srrw_pkg::ST_ACK: begin
        if (can_load) begin
          state_nxt = walk_r ? srrw_pkg::ST_DLV : srrw_pkg::ST_IDLE;
        end
      end
      srrw_pkg::ST_DLV: begin
        if (can_load) begin
          state_nxt = more ? srrw_pkg::ST_DLV : srrw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srrw_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = 1'b0;
    take      = 1'b0;
    store     = 1'b0;
    advance   = 1'b0;
    out_load  = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = ne_slot_r;
    out_data_nxt = out_data_r;
    case (state_r)
      srrw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        take     = in_valid;
      end
      srrw_pkg::ST_EVAL: begin
        store = in_win && is_new;
      end
      srrw_pkg::ST_ACK: begin
        out_load = can_load;
        // Prefetch the first block of the walk.
        ram_re   = can_load && walk_r;
        out_data_nxt.kind        = srrw_pkg::KIND_ACK;
        out_data_nxt.out_seq     = SeqW'(seq_r);
        out_data_nxt.out_len     = '0;
        out_data_nxt.out_payload = '0;
        out_data_nxt.last        = !walk_r;
        out_data_nxt.done_res    = fin_r;
      end
      srrw_pkg::ST_DLV: begin
        out_load  = can_load;
        advance   = can_load;
        ram_re    = can_load && more;
        ram_raddr = ne_slot_inc;
        out_data_nxt.kind        = srrw_pkg::KIND_DLV;
        out_data_nxt.out_seq     = SeqW'(ne_r);
        out_data_nxt.out_len     = ram_rdata[EntW-1:PayW];
        out_data_nxt.out_payload = ram_rdata[PayW-1:0];
        out_data_nxt.last        = !more;
        out_data_nxt.done_res    = fin_r || hit_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Register next values.
  always_comb begin
    seq_nxt      = seq_r;
    len_nxt      = len_r;
    pay_nxt      = pay_r;
    ne_nxt       = ne_r;
    ne_slot_nxt  = ne_slot_r;
    marks_nxt    = marks_r;
    fin_nxt      = fin_r;
    walk_nxt     = walk_r;
    last_seq_nxt = last_seq_r;
    if (take) begin
      seq_nxt = SEQ_BITS'(in_data.seq_no);
      len_nxt = in_data.block_len;
      pay_nxt = in_data.payload;
    end
    if (state_r == srrw_pkg::ST_EVAL) begin
      walk_nxt = walk_has;
    end
    if (store) begin
      marks_nxt[in_slot] = 1'b1;
    end
    if (advance) begin
      marks_nxt[ne_slot_r] = 1'b0;
      ne_nxt      = ne_inc;
      ne_slot_nxt = ne_slot_inc;
      fin_nxt     = fin_r || hit_last;
    end
    if (cfg_valid) begin
      last_seq_nxt = cfg_data;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srrw_pkg::ST_IDLE;
      ne_r        <= '0;
      ne_slot_r   <= '0;
      marks_r     <= '0;
      fin_r       <= 1'b0;
      last_seq_r  <= '0;
      walk_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ne_r        <= ne_nxt;
      ne_slot_r   <= ne_slot_nxt;
      marks_r     <= marks_nxt;
      fin_r       <= fin_nxt;
      last_seq_r  <= last_seq_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    len_r <= len_nxt;
    pay_r <= pay_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  srrw_ram #(
    .WIDTH(EntW),
    .DEPTH(WINDOW)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (store),
    .wr_addr(in_slot),
    .wr_data({len_r, pay_r}),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/srrw_chk.sv =====
// Port-level checker for the selective-repeat receive window, bound to the top level.
`timescale 1ns / 1ps

module srrw_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input srrw_pkg::frame_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input srrw_pkg::result_t out_data
);

  logic seen_done_r;

  // Track that a completed transfer has been reported.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_done_r <= 1'b0;
    end else if (out_valid && out_ready && out_data.done_res) begin
      seen_done_r <= 1'b1;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("offered item changed or withdrawn before it was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == srrw_pkg::KIND_ACK) |->
      (out_data.out_len == '0) && (out_data.out_payload == '0))
    else $error("acknowledgement carries length or payload");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("new item taken while results of the current one remain");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_done_r |-> out_data.done_res)
    else $error("done flag dropped after completion");

endmodule

bind selective_repeat_receive_window_unit srrw_chk u_srrw_chk (.*);
